// ===== hdl/rgbg_pkg.sv =====
`timescale 1ns / 1ps

package rgbg_pkg;

    localparam int PIX_W = 8;
    // top + 2*mid + bottom of 8-bit samples
    localparam int SUM_W = 10;
    // full 1-2-1 weighted sum of three column sums, before the /16
    localparam int ACC_W = 12;
    localparam int CFG_W = 11;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(1024);

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_t;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    // where one tap of the vertical 1-2-1 comes from
    typedef enum logic [1:0] {
        SRC_PIX   = 2'd0,
        SRC_LOWER = 2'd1,
        SRC_UPPER = 2'd2
    } src_t;

    // [2] red, [1] green, [0] blue
    typedef logic [2:0][PIX_W-1:0] rgb_t;
    typedef logic [2:0][SUM_W-1:0] col_sum_t;

    // decoded stream position, handed from the sequencer to the filter stage
    typedef struct packed {
        logic real_px;
        logic col0;
        logic has_res;
        logic eor;
        logic eof;
        src_t src_top;
        src_t src_mid;
        src_t src_bot;
        rgb_t pix;
    } step_t;

endpackage

// ===== hdl/rgbg_in_if.sv =====
`timescale 1ns / 1ps

interface rgbg_in_if;
    logic                       valid;
    logic                       ready;
    rgbg_pkg::req_t             req_type;
    logic [rgbg_pkg::PIX_W-1:0] in_red;
    logic [rgbg_pkg::PIX_W-1:0] in_green;
    logic [rgbg_pkg::PIX_W-1:0] in_blue;

    modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

// ===== hdl/rgbg_out_if.sv =====
`timescale 1ns / 1ps

interface rgbg_out_if;
    logic                       valid;
    logic                       ready;
    logic [rgbg_pkg::PIX_W-1:0] out_red;
    logic [rgbg_pkg::PIX_W-1:0] out_green;
    logic [rgbg_pkg::PIX_W-1:0] out_blue;
    logic                       end_of_row;
    logic                       end_of_frame;

    modport source (output valid, out_red, out_green, out_blue, end_of_row, end_of_frame,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, end_of_row, end_of_frame,
                    output ready);
endinterface

// ===== hdl/rgbg_ctrl.sv =====
`timescale 1ns / 1ps

module rgbg_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rgbg_pkg::req_t   in_req,
    input  rgbg_pkg::rgb_t   in_pix,
    input  logic [WW-1:0]    frame_w,
    input  logic [HW-1:0]    frame_h,
    input  logic             adv_ok,
    output logic             in_ready,
    output logic             step_valid,
    output rgbg_pkg::step_t  step,
    output logic [CW-1:0]    step_addr
);
    import rgbg_pkg::*;

    localparam int CXW = WW + 1;
    // rows run up to height + 1 while the frame drains
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int RXW = RW + 1;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic           drain_reg, drain_next;

    logic           skip_pend;
    logic           accept;
    logic           pix_go;
    logic           drain_go;
    logic           skip_go;
    logic           restart;
    logic [CW-1:0]  col;
    logic [RW-1:0]  row;
    logic [CXW-1:0] col_x, w_x;
    logic [RXW-1:0] row_x, h_x;
    logic           col_wrap;
    logic           row_last;
    logic           h_one;

    always_comb
    begin
        // one-row frame: the first drain position yields nothing, step over it here
        skip_pend  = drain_reg && (col_reg == '0) && (row_reg < RW'(2));
        in_ready   = adv_ok && !skip_pend;
        accept     = in_valid && in_ready;
        pix_go     = accept && (in_req == REQ_PIXEL);
        drain_go   = accept && (in_req == REQ_DRAIN) && drain_reg;
        skip_go    = skip_pend && adv_ok;
        step_valid = pix_go || drain_go || skip_go;

        // a pixel during drain drops what is pending and opens a new frame
        restart = pix_go && drain_reg;
        col     = restart ? '0 : col_reg;
        row     = restart ? '0 : row_reg;

        col_x    = CXW'(col);
        w_x      = CXW'(frame_w);
        row_x    = RXW'(row);
        h_x      = RXW'(frame_h);
        col_wrap = (col_x + CXW'(1)) >= w_x;
        row_last = (row_x + RXW'(1)) >= h_x;
        h_one    = (h_x == RXW'(1));

        step.real_px = pix_go;
        step.col0    = (col == '0);
        step.has_res = step.col0 ? (row_x >= RXW'(2)) : (row_x >= RXW'(1));
        step.eor     = step.col0 || (col_x >= w_x);
        step.eof     = step.eor &&
                       (step.col0 ? (row_x >= h_x + RXW'(1)) : (row_x >= h_x));
        step.pix     = in_pix;

        if (pix_go)
        begin
            priority if (row_x >= RXW'(2))
                step.src_top = SRC_UPPER;
            else if (row_x == RXW'(1))
                step.src_top = SRC_LOWER;
            else
                step.src_top = SRC_PIX;
            step.src_mid = (row_x >= RXW'(1)) ? SRC_LOWER : SRC_PIX;
            step.src_bot = SRC_PIX;
        end
        else
        begin
            // past the last row: rows clamp to the bottom edge
            step.src_top = ((row_x >= h_x + RXW'(1)) || h_one) ? SRC_LOWER : SRC_UPPER;
            step.src_mid = ((row_x >= h_x) || h_one) ? SRC_LOWER : SRC_UPPER;
            step.src_bot = row_last ? SRC_LOWER : SRC_UPPER;
        end

        step_addr = col;

        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (step_valid)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row + RW'(1);
            end
            else
            begin
                col_next = col + CW'(1);
                row_next = row;
            end
            if (pix_go)
                drain_next = row_last && col_wrap;
            else if (drain_go && step.has_res && step.eof)
            begin
                col_next   = '0;
                row_next   = '0;
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// ===== hdl/rgbg_line_store.sv =====
`timescale 1ns / 1ps

module rgbg_line_store #(
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  rgbg_pkg::rgb_t wr_pix,
    output rgbg_pkg::rgb_t upper_q,
    output rgbg_pkg::rgb_t lower_q
);
    import rgbg_pkg::*;

    rgb_t upper_mem [DEPTH];
    rgb_t lower_mem [DEPTH];

    rgb_t upper_rd_reg;
    rgb_t lower_rd_reg;
    rgb_t byp_upper_reg;
    rgb_t byp_lower_reg;
    logic byp_reg;

    // row shift: the entry moves from the lower store into the upper one
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr] <= lower_q;
            lower_mem[wr_addr] <= wr_pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            upper_rd_reg  <= upper_mem[rd_addr];
            lower_rd_reg  <= lower_mem[rd_addr];
            byp_upper_reg <= lower_q;
            byp_lower_reg <= wr_pix;
        end
    end

    // same-address write in the read cycle (one-pixel rows): take the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_reg <= 1'b0;
        else if (rd_en)
            byp_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign upper_q = byp_reg ? byp_upper_reg : upper_rd_reg;
    assign lower_q = byp_reg ? byp_lower_reg : lower_rd_reg;

endmodule

// ===== hdl/rgbg_window.sv =====
`timescale 1ns / 1ps

module rgbg_window #(
    parameter int AW = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_valid,
    input  rgbg_pkg::step_t step,
    input  logic [AW-1:0]   step_addr,
    input  rgbg_pkg::rgb_t  upper_q,
    input  rgbg_pkg::rgb_t  lower_q,
    output logic            adv_ok,
    output logic            wr_en,
    output logic [AW-1:0]   wr_addr,
    output rgbg_pkg::rgb_t  wr_pix,
    rgbg_out_if.source      results
);
    import rgbg_pkg::*;

    logic           b_valid_reg;
    step_t          b_step_reg;
    logic [AW-1:0]  b_addr_reg;
    col_sum_t       win_reg [3];
    logic           out_valid_reg;
    rgb_t           out_pix_reg;
    logic           out_eor_reg;
    logic           out_eof_reg;

    logic           b_go;
    rgb_t           pt, pm, pb;
    col_sum_t       s_sum;
    logic [ACC_W-1:0] acc [3];
    rgb_t           res_pix;

    function automatic rgb_t pick(input src_t sel, input rgb_t p, input rgb_t l, input rgb_t u);
        rgb_t r;
        unique case (sel)
            SRC_PIX:   r = p;
            SRC_LOWER: r = l;
            SRC_UPPER: r = u;
            default:   r = p;
        endcase
        return r;
    endfunction

    always_comb
    begin
        b_go   = b_valid_reg && (!b_step_reg.has_res || !out_valid_reg || results.ready);
        adv_ok = !b_valid_reg || b_go;

        pt = pick(b_step_reg.src_top, b_step_reg.pix, lower_q, upper_q);
        pm = pick(b_step_reg.src_mid, b_step_reg.pix, lower_q, upper_q);
        pb = pick(b_step_reg.src_bot, b_step_reg.pix, lower_q, upper_q);

        for (int k = 0; k < 3; k++)
        begin
            s_sum[k] = SUM_W'(pt[k]) + SUM_W'({pm[k], 1'b0}) + SUM_W'(pb[k]);
            if (b_step_reg.col0)
                // right edge replicated: L + 2C + R with R = C
                acc[k] = ACC_W'(win_reg[1][k]) + ACC_W'(win_reg[2][k])
                       + ACC_W'({win_reg[2][k], 1'b0});
            else
                acc[k] = ACC_W'(win_reg[1][k]) + ACC_W'({win_reg[2][k], 1'b0})
                       + ACC_W'(s_sum[k]);
            res_pix[k] = acc[k][ACC_W-1:4];
        end

        wr_en   = b_go && b_step_reg.real_px;
        wr_addr = b_addr_reg;
        wr_pix  = b_step_reg.pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv_ok)
            b_valid_reg <= step_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step_valid && adv_ok)
        begin
            b_step_reg <= step;
            b_addr_reg <= step_addr;
        end
    end

    // column 0 fills the window (left edge replicated), else shift left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
        end
        else if (b_go)
        begin
            if (b_step_reg.col0)
            begin
                win_reg[0] <= s_sum;
                win_reg[1] <= s_sum;
                win_reg[2] <= s_sum;
            end
            else
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= s_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_go && b_step_reg.has_res)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_go && b_step_reg.has_res)
        begin
            out_pix_reg <= res_pix;
            out_eor_reg <= b_step_reg.eor;
            out_eof_reg <= b_step_reg.eof;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.out_red      = out_pix_reg[2];
    assign results.out_green    = out_pix_reg[1];
    assign results.out_blue     = out_pix_reg[0];
    assign results.end_of_row   = out_eor_reg;
    assign results.end_of_frame = out_eof_reg;

endmodule

// ===== hdl/rgb_gaussian_blur_3x3_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Word                                          Handshake
// pixels    in   req_type, in_red, in_green, in_blue           valid/ready
// results   out  out_red, out_green, out_blue,                 valid/ready
//                end_of_row, end_of_frame
// cfg       in   cfg_index, cfg_data (frame_width, frame_height) cfg_we, no wait
//
// One word per clock in steady state. The word that releases a result passes
// sequencer -> filter stage with line store read -> result reg.
// After the last pixel of a one-row frame the sequencer inserts an internal
// step with pixels.ready low.
// Reset clears counters, window and valids; the line stores are not cleared.
// Stalls: the filter stage and the result register hold; a new word is taken
// while a result waits as long as the filter stage is empty or moving on.

module rgb_gaussian_blur_3x3_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rgbg_in_if.sink                     pixels,
    rgbg_out_if.source                  results,
    input  logic                        cfg_we,
    input  rgbg_pkg::cfg_idx_t          cfg_index,
    input  logic [rgbg_pkg::CFG_W-1:0]  cfg_data
);
    import rgbg_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;

    rgb_t             in_pix;
    logic             adv_ok;
    logic             step_valid;
    step_t            step;
    logic [CW-1:0]    step_addr;
    rgb_t             upper_q;
    rgb_t             lower_q;
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    rgb_t             wr_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RESET;
            height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // zero reads as 1, anything above the maximum as the maximum
    always_comb
    begin
        priority if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        priority if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    assign in_pix = {pixels.in_red, pixels.in_green, pixels.in_blue};

    // position counters, drain sequencing, tap source decode
    rgbg_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pixels.valid),
        .in_req     (pixels.req_type),
        .in_pix     (in_pix),
        .frame_w    (w_eff),
        .frame_h    (h_eff),
        .adv_ok     (adv_ok),
        .in_ready   (pixels.ready),
        .step_valid (step_valid),
        .step       (step),
        .step_addr  (step_addr)
    );

    // rows one and two back; read at the sequencer column, written by the filter stage
    rgbg_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (step_valid),
        .rd_addr (step_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_pix  (wr_pix),
        .upper_q (upper_q),
        .lower_q (lower_q)
    );

    // vertical sums, 3-column window, horizontal 1-2-1 and result register
    rgbg_window #(
        .AW (CW)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step       (step),
        .step_addr  (step_addr),
        .upper_q    (upper_q),
        .lower_q    (lower_q),
        .adv_ok     (adv_ok),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_pix     (wr_pix),
        .results    (results)
    );

endmodule

// ===== hdl/rgbg_checker.sv =====
`timescale 1ns / 1ps

module rgbg_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [rgbg_pkg::PIX_W-1:0] out_red,
    input logic [rgbg_pkg::PIX_W-1:0] out_green,
    input logic [rgbg_pkg::PIX_W-1:0] out_blue,
    input logic                       end_of_row,
    input logic                       end_of_frame
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable({out_red, out_green, out_blue, end_of_row, end_of_frame}))
        else $error("stalled result word changed");

    a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> end_of_row)
        else $error("end of frame without end of row");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without an input word two cycles earlier");

endmodule

bind rgb_gaussian_blur_3x3_unit rgbg_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pixels.valid),
    .in_ready     (pixels.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_red      (results.out_red),
    .out_green    (results.out_green),
    .out_blue     (results.out_blue),
    .end_of_row   (results.end_of_row),
    .end_of_frame (results.end_of_frame)
);

// ===== dv/rgbg_blur_checker.sv =====
`timescale 1ns / 1ps

// Watches the pixel, result and config ports, predicts every blurred pixel
// and compares it with what the block hands out.
module rgbg_blur_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rgbg_in_if                         pixels,
    rgbg_out_if                        results,
    input  logic                       cfg_we,
    input  rgbg_pkg::cfg_idx_t         cfg_index,
    input  logic [rgbg_pkg::CFG_W-1:0] cfg_data,
    output int                         errors,
    output int                         pending
);
    import rgbg_pkg::*;

    typedef struct packed {
        rgb_t px;
        logic eor;
        logic eof;
    } blur_res_t;

    rgb_t             upper_line [MAX_WIDTH];
    rgb_t             lower_line [MAX_WIDTH];
    // vertical 1-2-1 sums: [left, center, right][channel]
    int unsigned      win_sum [3][3];
    int               col_pos    = 0;
    int               row_pos    = 0;
    bit               draining   = 1'b0;
    logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RESET;
    int               fail_count = 0;
    blur_res_t        blurred_q [$];

    function automatic int eff_dim(input logic [CFG_W-1:0] v, input int cap);
        if (v == '0)
        begin
            return 1;
        end
        return (int'(v) > cap) ? cap : int'(v);
    endfunction

    function automatic int clip_row(input int v, input int lo, input int hi);
        if (v < lo)
        begin
            return lo;
        end
        return (v > hi) ? hi : v;
    endfunction

    // live pixel: the row being streamed or one of the stored rows;
    // drain position: only the stored rows, bottom row repeated
    function automatic rgb_t tap_pixel(input bit is_pixel, input int src_row, input int r,
                                       input int h, input int ci, input rgb_t pix);
        if (is_pixel)
        begin
            if (src_row == r)
            begin
                return pix;
            end
            if (src_row == r - 1)
            begin
                return lower_line[ci];
            end
            return upper_line[ci];
        end
        return (src_row >= h - 1) ? lower_line[ci] : upper_line[ci];
    endfunction

    // one stream position, live pixel or drain step
    task automatic blur_step(input bit is_pixel, input rgb_t pix,
                             output bit got, output blur_res_t res);
        int          w;
        int          h;
        int          c;
        int          ci;
        int          r;
        int          hi;
        int          orow;
        rgb_t        pt;
        rgb_t        pm;
        rgb_t        pb;
        int unsigned colsum [3];
        begin
            w    = eff_dim(width_reg, MAX_WIDTH);
            h    = eff_dim(height_reg, MAX_HEIGHT);
            c    = col_pos;
            ci   = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
            r    = row_pos;
            hi   = is_pixel ? r : h - 1;
            pt   = tap_pixel(is_pixel, clip_row(r - 2, 0, hi), r, h, ci, pix);
            pm   = tap_pixel(is_pixel, clip_row(r - 1, 0, hi), r, h, ci, pix);
            pb   = tap_pixel(is_pixel, clip_row(r, 0, hi), r, h, ci, pix);
            got  = 1'b0;
            res  = '0;
            orow = 0;
            for (int k = 0; k < 3; k++)
            begin
                colsum[k] = pt[k] + 2 * pm[k] + pb[k];
            end
            if (c == 0)
            begin
                // first column: release last pixel of the row two back,
                // its right neighbor clamped to itself
                if (r >= 2)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        res.px[k] = 8'((win_sum[1][k] + 3 * win_sum[2][k]) >> 4);
                    end
                    res.eor = 1'b1;
                    orow    = r - 2;
                    got     = 1'b1;
                end
                for (int k = 0; k < 3; k++)
                begin
                    win_sum[0][k] = colsum[k];
                    win_sum[1][k] = colsum[k];
                    win_sum[2][k] = colsum[k];
                end
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_sum[0][k] = win_sum[1][k];
                    win_sum[1][k] = win_sum[2][k];
                    win_sum[2][k] = colsum[k];
                end
                if (r >= 1)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        res.px[k] = 8'((win_sum[0][k] + 2 * win_sum[1][k] + win_sum[2][k]) >> 4);
                    end
                    res.eor = (c >= w);
                    orow    = r - 1;
                    got     = 1'b1;
                end
            end
            if (got)
            begin
                res.eof = res.eor && (orow >= h - 1);
            end
            if (is_pixel)
            begin
                upper_line[ci] = lower_line[ci];
                lower_line[ci] = pix;
            end
            if (c + 1 >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            else
            begin
                col_pos = c + 1;
            end
        end
    endtask

    task automatic take_word(input req_t kind, input rgb_t pix);
        bit        got;
        bit        frame_done;
        blur_res_t res;
        begin
            if (kind == REQ_PIXEL)
            begin
                // a pixel during drain drops what is pending, new frame
                if (draining)
                begin
                    draining = 1'b0;
                    row_pos  = 0;
                    col_pos  = 0;
                end
                frame_done = (row_pos + 1 >= eff_dim(height_reg, MAX_HEIGHT)) &&
                             (col_pos + 1 >= eff_dim(width_reg, MAX_WIDTH));
                blur_step(1'b1, pix, got, res);
                if (got)
                begin
                    blurred_q.push_back(res);
                end
                if (frame_done)
                begin
                    draining = 1'b1;
                end
            end
            else if (draining)
            begin
                // one-row frame: the first drain skips an empty position
                blur_step(1'b0, '0, got, res);
                if (!got)
                begin
                    blur_step(1'b0, '0, got, res);
                end
                if (got)
                begin
                    blurred_q.push_back(res);
                    if (res.eof)
                    begin
                        draining = 1'b0;
                        row_pos  = 0;
                        col_pos  = 0;
                    end
                end
            end
        end
    endtask

    function automatic void check_field(input string name, input int want, input int seen);
        if (want != seen)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, seen);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        blur_res_t want;
        if (!rst_n)
        begin
            col_pos    = 0;
            row_pos    = 0;
            draining   = 1'b0;
            width_reg  = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_sum[j][k] = 0;
                end
            end
            blurred_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  width_reg  = cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (pixels.valid && pixels.ready)
            begin
                take_word(pixels.req_type, {pixels.in_red, pixels.in_green, pixels.in_blue});
            end
            if (results.valid && results.ready)
            begin
                if (blurred_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none actual r %0d g %0d b %0d",
                             $time, results.out_red, results.out_green, results.out_blue);
                end
                else
                begin
                    want = blurred_q.pop_front();
                    check_field("out_red", want.px[2], results.out_red);
                    check_field("out_green", want.px[1], results.out_green);
                    check_field("out_blue", want.px[0], results.out_blue);
                    check_field("end_of_row", want.eor, results.end_of_row);
                    check_field("end_of_frame", want.eof, results.end_of_frame);
                end
            end
        end
        pending <= blurred_q.size();
        errors  <= fail_count;
    end

endmodule

// ===== dv/tb_rgb_gaussian_blur_3x3_unit.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the RGB 3x3 blur. Prediction and comparison live
// in rgbg_blur_checker, which reports its failure count and the number of
// results still owed.
module tb_rgb_gaussian_blur_3x3_unit;
    import rgbg_pkg::*;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    rgbg_in_if  pixels ();
    rgbg_out_if results ();

    int errors;
    int pending;

    // calm: no idling on either side
    bit calm         = 1'b0;
    // asks the result side for one long hold-off
    bit hold_results = 1'b0;

    int pixel_count    = 0;
    int drain_count    = 0;
    int frame_count    = 0;
    int geometry_count = 0;

    always #10 clk = ~clk;

    rgb_gaussian_blur_3x3_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rgbg_blur_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // Channel values lean on 0 and 255 so the largest sums and every bit of
    // the channels get exercised.
    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic rgb_t rand_pixel();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    // Offer one word and hold it until taken. Called at a clock edge, returns
    // at one. A random gap may follow; valid is only lowered when a gap is
    // taken, so valid never sees two updates in one step.
    task automatic send(input req_t kind, input rgb_t pix);
        pixels.valid    <= 1'b1;
        pixels.req_type <= kind;
        pixels.in_red   <= pix[2];
        pixels.in_green <= pix[1];
        pixels.in_blue  <= pix[0];
        @(posedge clk);
        while (!pixels.ready)
        begin
            @(posedge clk);
        end
        if (kind == REQ_PIXEL)
        begin
            pixel_count++;
        end
        else
        begin
            drain_count++;
        end
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            pixels.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Sender pause: every owed result has to come out. A trailing ignored
    // drain may still be in the pipe, so the wait goes on once nothing is owed.
    task automatic wait_idle();
        pixels.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // Both registers back to back; only ever called with the block idle.
    task automatic set_geometry(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= wv;
        @(posedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= hv;
        @(posedge clk);
        cfg_we <= 1'b0;
        geometry_count++;
    endtask

    // One frame of random pixels followed by some drain words. Noisy frames
    // get stray drains between pixels; mid-frame they are ignored.
    task automatic send_frame(input int w, input int h, input int drains, input bit noisy);
        for (int i = 0; i < w * h; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
            begin
                send(REQ_DRAIN, rand_pixel());
            end
            send(REQ_PIXEL, rand_pixel());
        end
        repeat (drains) send(REQ_DRAIN, rand_pixel());
        frame_count++;
    endtask

    // Result side: random stall bursts, one long hold-off on request, none
    // while calm.
    initial
    begin : result_side
        results.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        results.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                // long enough to back the block up into its input
                results.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_results = 1'b0;
                results.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                results.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        rgb_t             grid [9];
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        int               w;
        int               h;
        int               nframes;
        int               drains;
        int               random_start;
        pixels.valid    = 1'b0;
        pixels.req_type = REQ_PIXEL;
        pixels.in_red   = '0;
        pixels.in_green = '0;
        pixels.in_blue  = '0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_FRAME_WIDTH;
        cfg_data        = '0;
        grid = '{{8'hFF, 8'hFF, 8'hFF}, {8'h00, 8'h00, 8'h00}, {8'hFF, 8'h00, 8'hAA},
                 {8'h00, 8'hFF, 8'h55}, {8'h55, 8'hAA, 8'hFF}, {8'hAA, 8'h55, 8'h00},
                 {8'hFF, 8'hFF, 8'hFF}, {8'h00, 8'h00, 8'h00}, {8'h80, 8'h7F, 8'h01}};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // 3x3 frame: a drain with nothing pending first, then extremes,
        // then exactly the four drains that are owed
        set_geometry(11'd3, 11'd3);
        send(REQ_DRAIN, grid[8]);
        for (int i = 0; i < 9; i++)
        begin
            send(REQ_PIXEL, grid[i]);
        end
        repeat (4) send(REQ_DRAIN, '0);
        frame_count++;
        wait_idle();

        // single-row frame, drain cut short by a pixel that starts the next
        // frame, which then drains fully
        set_geometry(11'd3, 11'd1);
        for (int i = 0; i < 3; i++)
        begin
            send(REQ_PIXEL, grid[i]);
        end
        send(REQ_DRAIN, '1);
        for (int i = 3; i < 6; i++)
        begin
            send(REQ_PIXEL, grid[i]);
        end
        repeat (4) send(REQ_DRAIN, '0);
        frame_count += 2;
        wait_idle();

        // --- pressure: results held off while pixels keep coming ---
        set_geometry(11'd8, 11'd6);
        hold_results = 1'b1;
        send_frame(8, 6, 9, 1'b0);
        wait_idle();

        // --- smallest geometry: zero registers clamp to 1, 1x1 frames ---
        set_geometry(11'd0, 11'd0);
        send_frame(1, 1, 1, 1'b0);
        send_frame(1, 1, 0, 1'b0);
        send_frame(1, 1, 2, 1'b0);
        wait_idle();

        // --- random: small geometries, some drains cut short, stray drains;
        //     the last stretch runs with no idling at all ---
        random_start = pixel_count + drain_count;
        while (pixel_count + drain_count - random_start < 660)
        begin
            wv = 11'($urandom_range(0, 12));
            hv = 11'($urandom_range(0, 6));
            w  = (wv == '0) ? 1 : int'(wv);
            h  = (hv == '0) ? 1 : int'(hv);
            nframes = $urandom_range(1, 3);
            wait_idle();
            set_geometry(wv, hv);
            if (pixel_count + drain_count - random_start > 540)
            begin
                calm = 1'b1;
            end
            else
            begin
                calm = ($urandom_range(0, 3) == 0);
            end
            for (int f = 0; f < nframes; f++)
            begin
                // only the last frame of a setting must fully drain
                if (f < nframes - 1 && $urandom_range(0, 2) == 0)
                begin
                    drains = $urandom_range(0, w);
                end
                else
                begin
                    drains = w + 1 + $urandom_range(0, 1);
                end
                send_frame(w, h, drains, 1'b1);
            end
        end

        calm = 1'b1;
        wait_idle();
        repeat (10) @(posedge clk);

        $display("run covered %0d pixel words and %0d drain words, %0d frames",
                 pixel_count, drain_count, frame_count);
        $display("over %0d geometry settings from 1x1 up to 12 wide and 6 tall",
                 geometry_count);
        if (errors == 0 && pending == 0)
        begin
            $display("tb_rgb_gaussian_blur_3x3_unit passed");
        end
        else
        begin
            $display("tb_rgb_gaussian_blur_3x3_unit failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin : watchdog
        #(64'd20_000_000);
        $display("tb_rgb_gaussian_blur_3x3_unit failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rgbg_pkg.sv
hdl/rgbg_in_if.sv
hdl/rgbg_out_if.sv
hdl/rgbg_ctrl.sv
hdl/rgbg_line_store.sv
hdl/rgbg_window.sv
hdl/rgb_gaussian_blur_3x3_unit.sv
hdl/rgbg_checker.sv
dv/rgbg_blur_checker.sv
dv/tb_rgb_gaussian_blur_3x3_unit.sv
